// ----- rtl/core/cer_pkg.sv -----
// ----------------------------------------------------------------------------
// cer_pkg
// Types, constants and the ordering function of the complex eigenvalue
// sorter.
// ----------------------------------------------------------------------------
package cer_pkg;

  localparam int MAX_COUNT  = 64;
  localparam int VALUE_BITS = 24;
  localparam int IDX_BITS   = 6;
  localparam int COUNT_BITS = $clog2(MAX_COUNT + 1);
  localparam int KEY_BITS   = 2 * VALUE_BITS + 1;
  localparam int KEY_LAT    = 2;
  localparam int RING_LEN   = MAX_COUNT + KEY_LAT;
  localparam int CYC_BITS   = $clog2(RING_LEN);

  localparam logic [1:0] CFG_SHIFT_ENABLE = 2'd0;
  localparam logic [1:0] CFG_SHIFT_REAL   = 2'd1;
  localparam logic [1:0] CFG_SHIFT_IMAG   = 2'd2;

  typedef struct packed {
    logic signed [VALUE_BITS-1:0] value_real;
    logic signed [VALUE_BITS-1:0] value_imag;
    logic                         last_in;
  } in_item_t;

  typedef struct packed {
    logic signed [VALUE_BITS-1:0] sorted_real;
    logic signed [VALUE_BITS-1:0] sorted_imag;
    logic [IDX_BITS-1:0]          original_index;
    logic                         dropped_flag;
    logic                         last_out;
  } out_item_t;

  // one stored value with its sort keys
  typedef struct packed {
    logic signed [VALUE_BITS-1:0] re;
    logic signed [VALUE_BITS-1:0] im;
    logic [IDX_BITS-1:0]          index;
    logic [KEY_BITS-1:0]          dkey;
    logic [KEY_BITS-1:0]          mkey;
  } entry_t;

  typedef struct packed {
    logic                         enable;
    logic signed [VALUE_BITS-1:0] re;
    logic signed [VALUE_BITS-1:0] im;
  } shift_cfg_t;

  typedef enum logic [1:0] {
    CELL_HOLD,
    CELL_SHIFT,
    CELL_SORT
  } cell_mode_t;

  typedef struct packed {
    cell_mode_t mode;
    logic       lead;
  } cell_ctrl_t;

  typedef enum logic [1:0] {
    ST_LOAD,
    ST_KEYS,
    ST_SORT,
    ST_OUT
  } state_t;

  // true if a must come out strictly before b; empty slots go last
  function automatic logic entry_before(input logic av, input entry_t a,
                                        input logic bv, input entry_t b);
    logic r;
    if (!av) begin
      r = 1'b0;
    end else if (!bv) begin
      r = 1'b1;
    end else if (a.dkey != b.dkey) begin
      r = a.dkey < b.dkey;
    end else if (a.re != b.re) begin
      r = a.re < b.re;
    end else if (a.mkey != b.mkey) begin
      r = a.mkey < b.mkey;
    end else begin
      r = a.index < b.index;
    end
    return r;
  endfunction

endpackage

// ----- rtl/core/cer_cell.sv -----
// ----------------------------------------------------------------------------
// cer_cell
// One slot of the sort chain: holds, shifts from its left neighbor, or takes
// part in an odd-even exchange with a neighbor.
// ----------------------------------------------------------------------------
module cer_cell
  import cer_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  input  cell_ctrl_t ctrl,
  input  logic       prev_vld,
  input  entry_t     prev,
  input  logic       next_vld,
  input  entry_t     next,
  input  logic       swap_in,
  output logic       swap_out,
  output logic       vld,
  output entry_t     entry
);

  logic   vld_next;
  entry_t entry_next;

  // the tail side holds the earlier item, so a leading cell hands its item on
  // when it must come out before its right neighbor
  assign swap_out = (ctrl.mode == CELL_SORT) && ctrl.lead &&
                    entry_before(vld, entry, next_vld, next);

  always_comb begin
    vld_next   = vld;
    entry_next = entry;
    unique case (ctrl.mode)
      CELL_HOLD: begin
        vld_next   = vld;
        entry_next = entry;
      end
      CELL_SHIFT: begin
        vld_next   = prev_vld;
        entry_next = prev;
      end
      CELL_SORT: begin
        if (swap_out) begin
          vld_next   = next_vld;
          entry_next = next;
        end else if (swap_in) begin
          vld_next   = prev_vld;
          entry_next = prev;
        end
      end
      default: begin
        vld_next   = vld;
        entry_next = entry;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= 1'b0;
    end else begin
      vld <= vld_next;
    end
  end

  always_ff @(posedge clk) begin
    entry <= entry_next;
  end

endmodule

// ----- rtl/core/cer_key_unit.sv -----
// ----------------------------------------------------------------------------
// cer_key_unit
// Two-stage key pipeline in the ring: squared distance from the shift (zero
// when the shift is off) and squared magnitude of each item that passes.
// ----------------------------------------------------------------------------
module cer_key_unit
  import cer_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  input  logic       en,
  input  shift_cfg_t shift,
  input  logic       in_vld,
  input  entry_t     in_entry,
  output logic       out_vld,
  output entry_t     out_entry
);

  logic                    s1_vld;
  entry_t                  s1_entry;
  logic [VALUE_BITS-1:0]   s1_dr, s1_di, s1_mr, s1_mi;
  logic                    s2_vld;
  entry_t                  s2_entry;
  logic [2*VALUE_BITS-1:0] s2_dr, s2_di, s2_mr, s2_mi;

  function automatic logic [VALUE_BITS-1:0] abs_diff(input logic signed [VALUE_BITS-1:0] a,
                                                     input logic signed [VALUE_BITS-1:0] b);
    logic signed [VALUE_BITS:0] d;
    logic signed [VALUE_BITS:0] m;
    d = (VALUE_BITS+1)'(a) - (VALUE_BITS+1)'(b);
    m = d[VALUE_BITS] ? -d : d;
    return m[VALUE_BITS-1:0];
  endfunction

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_vld <= 1'b0;
      s2_vld <= 1'b0;
    end else if (en) begin
      s1_vld <= in_vld;
      s2_vld <= s1_vld;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s1_entry <= in_entry;
      s1_dr    <= shift.enable ? abs_diff(in_entry.re, shift.re) : '0;
      s1_di    <= shift.enable ? abs_diff(in_entry.im, shift.im) : '0;
      s1_mr    <= abs_diff(in_entry.re, '0);
      s1_mi    <= abs_diff(in_entry.im, '0);
      s2_entry <= s1_entry;
      s2_dr    <= s1_dr * s1_dr;
      s2_di    <= s1_di * s1_di;
      s2_mr    <= s1_mr * s1_mr;
      s2_mi    <= s1_mi * s1_mi;
    end
  end

  always_comb begin
    out_vld        = s2_vld;
    out_entry      = s2_entry;
    out_entry.dkey = {1'b0, s2_dr} + {1'b0, s2_di};
    out_entry.mkey = {1'b0, s2_mr} + {1'b0, s2_mi};
  end

endmodule

// ----- rtl/core/complex_eigenvalue_sorter.sv -----
// ----------------------------------------------------------------------------
// complex_eigenvalue_sorter
// Loading takes one item per cycle while in the load state. After the item
// with last_in, keys are formed in a ring pass through the key unit, then
// MAX_COUNT odd-even exchange rounds sort the chain; results then follow at
// one result per cycle while result_stall is low. Synchronous reset empties the
// chain and clears count, overflow flag and shift registers.
// ----------------------------------------------------------------------------
module complex_eigenvalue_sorter
  import cer_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  item_valid,
  output logic                  item_stall,
  input  in_item_t              item,
  output logic                  result_valid,
  input  logic                  result_stall,
  output out_item_t             result,
  input  logic                  cfg_we,
  input  logic [1:0]            cfg_index,
  input  logic [VALUE_BITS-1:0] cfg_data
);

  state_t                state, state_next;
  logic [COUNT_BITS-1:0] count, count_next;
  logic [CYC_BITS-1:0]   cyc, cyc_next;
  logic                  overflow, overflow_next;
  shift_cfg_t            shift;

  logic [MAX_COUNT-1:0]  cell_vld;
  entry_t                cell_entry [MAX_COUNT];
  logic [MAX_COUNT-1:0]  swap;
  cell_ctrl_t            ctrl [MAX_COUNT];
  cell_mode_t            mode;
  logic                  phase;

  logic                  head_vld;
  entry_t                head_entry;
  logic                  key_vld;
  entry_t                key_entry;
  logic                  in_acc, out_acc, full;

  assign in_acc  = item_valid && !item_stall;
  assign out_acc = result_valid && !result_stall;
  assign full    = count == COUNT_BITS'(MAX_COUNT);
  assign phase   = cyc[0];

  // configuration
  always_ff @(posedge clk) begin
    if (rst) begin
      shift <= '0;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_SHIFT_ENABLE: shift.enable <= cfg_data[0];
        CFG_SHIFT_REAL:   shift.re     <= cfg_data;
        CFG_SHIFT_IMAG:   shift.im     <= cfg_data;
        default:          shift        <= shift;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= ST_LOAD;
      count    <= '0;
      cyc      <= '0;
      overflow <= 1'b0;
    end else begin
      state    <= state_next;
      count    <= count_next;
      cyc      <= cyc_next;
      overflow <= overflow_next;
    end
  end

  always_comb begin
    state_next    = state;
    count_next    = count;
    cyc_next      = cyc;
    overflow_next = overflow;
    item_stall    = 1'b1;
    result_valid  = 1'b0;
    mode          = CELL_HOLD;
    head_vld      = 1'b0;
    head_entry    = key_entry;
    unique case (state)
      ST_LOAD: begin
        item_stall       = 1'b0;
        head_vld         = 1'b1;
        head_entry       = '0;
        head_entry.re    = item.value_real;
        head_entry.im    = item.value_imag;
        head_entry.index = IDX_BITS'(count);
        if (in_acc) begin
          if (full) begin
            overflow_next = 1'b1;
          end else begin
            mode       = CELL_SHIFT;
            count_next = count + 1'b1;
          end
          if (item.last_in) begin
            state_next = ST_KEYS;
            cyc_next   = '0;
          end
        end
      end
      ST_KEYS: begin
        mode     = CELL_SHIFT;
        head_vld = key_vld;
        cyc_next = cyc + 1'b1;
        if (cyc == CYC_BITS'(RING_LEN - 1)) begin
          state_next = ST_SORT;
          cyc_next   = '0;
        end
      end
      ST_SORT: begin
        mode     = CELL_SORT;
        cyc_next = cyc + 1'b1;
        if (cyc == CYC_BITS'(MAX_COUNT - 1)) begin
          state_next = ST_OUT;
          cyc_next   = '0;
        end
      end
      ST_OUT: begin
        result_valid = cell_vld[MAX_COUNT-1];
        if (out_acc) begin
          mode       = CELL_SHIFT;
          count_next = count - 1'b1;
          if (count == COUNT_BITS'(1)) begin
            state_next    = ST_LOAD;
            overflow_next = 1'b0;
          end
        end
      end
      default: begin
        state_next = ST_LOAD;
      end
    endcase
  end

  cer_key_unit u_key (
    .clk      (clk),
    .rst      (rst),
    .en       (state == ST_KEYS),
    .shift    (shift),
    .in_vld   (cell_vld[MAX_COUNT-1]),
    .in_entry (cell_entry[MAX_COUNT-1]),
    .out_vld  (key_vld),
    .out_entry(key_entry)
  );

  for (genvar g = 0; g < MAX_COUNT; g++) begin : g_cell
    logic   p_vld, n_vld, s_in;
    entry_t p_entry, n_entry;

    assign ctrl[g].mode = mode;
    assign ctrl[g].lead = (g < MAX_COUNT - 1) && (phase == 1'(g % 2));

    if (g == 0) begin : g_head
      assign p_vld   = head_vld;
      assign p_entry = head_entry;
      assign s_in    = 1'b0;
    end else begin : g_body
      assign p_vld   = cell_vld[g-1];
      assign p_entry = cell_entry[g-1];
      assign s_in    = swap[g-1];
    end

    if (g == MAX_COUNT - 1) begin : g_tail
      assign n_vld   = 1'b0;
      assign n_entry = '0;
    end else begin : g_inner
      assign n_vld   = cell_vld[g+1];
      assign n_entry = cell_entry[g+1];
    end

    cer_cell u_cell (
      .clk     (clk),
      .rst     (rst),
      .ctrl    (ctrl[g]),
      .prev_vld(p_vld),
      .prev    (p_entry),
      .next_vld(n_vld),
      .next    (n_entry),
      .swap_in (s_in),
      .swap_out(swap[g]),
      .vld     (cell_vld[g]),
      .entry   (cell_entry[g])
    );
  end

  always_comb begin
    result.sorted_real    = cell_entry[MAX_COUNT-1].re;
    result.sorted_imag    = cell_entry[MAX_COUNT-1].im;
    result.original_index = cell_entry[MAX_COUNT-1].index;
    result.dropped_flag   = overflow;
    result.last_out       = count == COUNT_BITS'(1);
  end

`ifndef SYNTH
  // stored items sit in the chain one per valid cell while loading
  a_load_count: assert property (@(posedge clk) disable iff (rst)
    (state == ST_LOAD) |-> ($countones(cell_vld) == int'(count)))
    else $error("valid cells do not match item count");

  a_count_max: assert property (@(posedge clk) disable iff (rst)
    count <= COUNT_BITS'(MAX_COUNT))
    else $error("item count above capacity");

  // sorted items sit at the tail until the set is drained
  a_out_tail: assert property (@(posedge clk) disable iff (rst)
    (state == ST_OUT) |-> (cell_vld[MAX_COUNT-1] == (count != '0)))
    else $error("tail cell empty while results remain");

  a_last_done: assert property (@(posedge clk) disable iff (rst)
    (out_acc && result.last_out) |=> (state == ST_LOAD && count == '0 && !overflow))
    else $error("set not closed after last result");
`endif

endmodule

// ----- sim/tb_top.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Testbench for complex_eigenvalue_sorter. Sets of complex values are loaded
// with random bursts and gaps while the result side stalls on its own
// pattern. A local sort model predicts every sorted item of a set, and each
// item that leaves the block is compared field by field with it.
// ----------------------------------------------------------------------------
module tb_top;
  import cer_pkg::*;

  localparam int ITEM_GOAL   = 240;
  localparam int CYCLE_LIMIT = 1500000;
  localparam int SETTLE      = 2 * MAX_COUNT + 16;
  localparam int HOLD_CYCLES = 400;
  localparam logic [VALUE_BITS-1:0] VMAX = {1'b0, {(VALUE_BITS-1){1'b1}}};
  localparam logic [VALUE_BITS-1:0] VMIN = {1'b1, {(VALUE_BITS-1){1'b0}}};

  logic                  clk = 1'b0;
  logic                  rst;
  logic                  item_valid;
  logic                  item_stall;
  in_item_t              item;
  logic                  result_valid;
  logic                  result_stall = 1'b0;
  out_item_t             result;
  logic                  cfg_we;
  logic [1:0]            cfg_index;
  logic [VALUE_BITS-1:0] cfg_data;

  complex_eigenvalue_sorter dut (
    .clk          (clk),
    .rst          (rst),
    .item_valid   (item_valid),
    .item_stall   (item_stall),
    .item         (item),
    .result_valid (result_valid),
    .result_stall (result_stall),
    .result       (result),
    .cfg_we       (cfg_we),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data)
  );

  always #1 clk = ~clk;

  // sort model state: current set and shadow of the shift registers
  int        set_re[$];
  int        set_im[$];
  bit        set_dropped;
  bit        sh_en;
  int        sh_re;
  int        sh_im;
  out_item_t sorted_q[$];

  int mismatch_count = 0;
  int cycle_count    = 0;
  int burst_left     = 0;
  int hold_reqs      = 0;
  int holds_started  = 0;
  int hold_left      = 0;
  int stall_mode     = 0;
  int mode_left      = 0;
  int stall_phase    = 0;

  logic [VALUE_BITS-1:0] pending_re[$];
  logic [VALUE_BITS-1:0] pending_im[$];
  logic [VALUE_BITS-1:0] pool_r[4];
  logic [VALUE_BITS-1:0] pool_i[4];

  function automatic longint sq_dist(int r, int i, int cr, int ci);
    longint dr;
    longint di;
    dr = longint'(r) - longint'(cr);
    di = longint'(i) - longint'(ci);
    return dr * dr + di * di;
  endfunction

  // slot a strictly ahead of slot b; equal keys keep load order
  function automatic bit comes_first(int a, int b);
    longint ka;
    longint kb;
    if (sh_en) begin
      ka = sq_dist(set_re[a], set_im[a], sh_re, sh_im);
      kb = sq_dist(set_re[b], set_im[b], sh_re, sh_im);
      if (ka != kb) return ka < kb;
    end
    if (set_re[a] != set_re[b]) return set_re[a] < set_re[b];
    ka = sq_dist(set_re[a], set_im[a], 0, 0);
    kb = sq_dist(set_re[b], set_im[b], 0, 0);
    return ka < kb;
  endfunction

  function automatic void close_set();
    int        order[MAX_COUNT];
    int        n;
    int        i;
    int        j;
    out_item_t e;
    n = set_re.size();
    for (i = 0; i < n; i++) begin
      j = i;
      while (j > 0 && comes_first(i, order[j-1])) begin
        order[j] = order[j-1];
        j--;
      end
      order[j] = i;
    end
    for (i = 0; i < n; i++) begin
      e.sorted_real    = VALUE_BITS'(set_re[order[i]]);
      e.sorted_imag    = VALUE_BITS'(set_im[order[i]]);
      e.original_index = IDX_BITS'(order[i]);
      e.dropped_flag   = set_dropped;
      e.last_out       = (i == n - 1);
      sorted_q.push_back(e);
    end
    set_re.delete();
    set_im.delete();
    set_dropped = 1'b0;
  endfunction

  function automatic void record_item(logic [VALUE_BITS-1:0] re,
                                      logic [VALUE_BITS-1:0] im, bit last);
    if (set_re.size() < MAX_COUNT) begin
      set_re.push_back($signed(re));
      set_im.push_back($signed(im));
    end else begin
      set_dropped = 1'b1;
    end
    if (last) close_set();
  endfunction

  task automatic report_error(input string msg);
    if (mismatch_count < 30) $display("ERROR: %s", msg);
    mismatch_count++;
  endtask

  task automatic item_idle(input int n);
    repeat (n) begin
      @(negedge clk);
      item_valid <= 1'b0;
    end
  endtask

  task automatic send_item(input logic [VALUE_BITS-1:0] re,
                           input logic [VALUE_BITS-1:0] im, input bit last);
    in_item_t it;
    int       gap;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 24);
      gap = ($urandom_range(0, 3) == 0) ? 0 :
            $urandom_range(1, ($urandom_range(0, 4) == 0) ? 30 : 4);
      item_idle(gap);
    end
    burst_left--;
    it.value_real = re;
    it.value_imag = im;
    it.last_in    = last;
    @(negedge clk);
    item_valid <= 1'b1;
    item       <= it;
    do @(posedge clk); while (item_stall);
    record_item(re, im, last);
  endtask

  task automatic queue_value(input logic [VALUE_BITS-1:0] re,
                             input logic [VALUE_BITS-1:0] im);
    pending_re.push_back(re);
    pending_im.push_back(im);
  endtask

  task automatic send_pending();
    int i;
    for (i = 0; i < pending_re.size(); i++)
      send_item(pending_re[i], pending_im[i], i == pending_re.size() - 1);
    pending_re.delete();
    pending_im.delete();
  endtask

  // sender pauses until every predicted item is out and the block has settled
  task automatic wait_for_results();
    @(negedge clk);
    item_valid <= 1'b0;
    while (sorted_q.size() != 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);
  endtask

  task automatic write_reg(input logic [1:0] idx, input logic [VALUE_BITS-1:0] data);
    @(negedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    @(negedge clk);
    cfg_we <= 1'b0;
    case (idx)
      CFG_SHIFT_ENABLE: sh_en = data[0];
      CFG_SHIFT_REAL:   sh_re = $signed(data);
      CFG_SHIFT_IMAG:   sh_im = $signed(data);
      default: ;
    endcase
  endtask

  task automatic set_shift(input bit en, input logic [VALUE_BITS-1:0] re,
                           input logic [VALUE_BITS-1:0] im);
    write_reg(CFG_SHIFT_ENABLE, {{(VALUE_BITS-1){1'b0}}, en});
    write_reg(CFG_SHIFT_REAL, re);
    write_reg(CFG_SHIFT_IMAG, im);
  endtask

  function automatic logic [VALUE_BITS-1:0] pick_shift();
    case ($urandom_range(0, 4))
      0:       return VMAX;
      1:       return VMIN;
      2:       return '0;
      3:       return VALUE_BITS'($urandom_range(0, 64) - 32);
      default: return VALUE_BITS'($urandom);
    endcase
  endfunction

  function automatic logic [VALUE_BITS-1:0] pick_value(int mode, bit imag_part);
    case (mode)
      0: return VALUE_BITS'($urandom);
      1: return imag_part ? pool_i[$urandom_range(0, 3)] : pool_r[$urandom_range(0, 3)];
      default: begin
        if (imag_part) return '0;
        if ($urandom_range(0, 7) == 0) return $urandom_range(0, 1) ? VMAX : VMIN;
        return VALUE_BITS'($urandom);
      end
    endcase
  endfunction

  function automatic int pick_size();
    int r;
    r = $urandom_range(0, 99);
    if (r < 65) return $urandom_range(1, 10);
    if (r < 88) return $urandom_range(11, 40);
    if (r < 97) return $urandom_range(41, MAX_COUNT);
    return $urandom_range(MAX_COUNT + 1, MAX_COUNT + 6);
  endfunction

  // field extremes, shift off
  task automatic test_extremes();
    queue_value(VMAX, VMIN);
    queue_value(VMIN, VMAX);
    queue_value(VMIN, VMIN);
    queue_value(VMAX, VMAX);
    queue_value('0, '0);
    queue_value('1, '1);
    queue_value(VALUE_BITS'(1), '0);
    queue_value(VMIN, '0);
    send_pending();
    wait_for_results();
  endtask

  // equal real parts ordered by magnitude, full ties keep load order
  task automatic test_ties();
    queue_value(VALUE_BITS'(5), VALUE_BITS'(3));
    queue_value(VALUE_BITS'(5), VALUE_BITS'(-3));
    queue_value(VALUE_BITS'(5), VALUE_BITS'(1));
    queue_value(VALUE_BITS'(5), VALUE_BITS'(3));
    queue_value(VALUE_BITS'(-2), '0);
    queue_value(VALUE_BITS'(5), VALUE_BITS'(-3));
    queue_value(VALUE_BITS'(5), '0);
    queue_value(VALUE_BITS'(-2), '0);
    send_pending();
    wait_for_results();
  endtask

  task automatic test_shift_order();
    int s;
    for (s = 0; s < 2; s++) begin
      set_shift(1'b1, s ? VMIN : VMAX, s ? VMIN : VMAX);
      queue_value(VMAX, VMAX);
      queue_value(VMIN, VMIN);
      queue_value(VMAX - 1, VMAX);
      queue_value(VMAX, VMAX - 1);
      queue_value('0, '0);
      queue_value(VMIN, VMAX);
      send_pending();
      wait_for_results();
    end
    // equal distance from the shift: real part decides, then load order
    set_shift(1'b1, '0, '0);
    queue_value(VALUE_BITS'(3), VALUE_BITS'(4));
    queue_value(VALUE_BITS'(-3), VALUE_BITS'(4));
    queue_value(VALUE_BITS'(4), VALUE_BITS'(3));
    queue_value(VALUE_BITS'(5), '0);
    queue_value('0, VALUE_BITS'(-5));
    queue_value(VALUE_BITS'(3), VALUE_BITS'(-4));
    send_pending();
    wait_for_results();
    set_shift(1'b0, VMAX, VMIN);
    queue_value(VALUE_BITS'(7), VALUE_BITS'(1));
    queue_value(VMAX, VMIN);
    queue_value(VALUE_BITS'(-7), VALUE_BITS'(2));
    send_pending();
    wait_for_results();
  endtask

  // single item set, full set, and a set whose last three items are dropped
  task automatic test_capacity();
    int k;
    send_item(VMIN, VMAX, 1'b1);
    for (k = 0; k < MAX_COUNT; k++)
      send_item(VALUE_BITS'($urandom), VALUE_BITS'($urandom), k == MAX_COUNT - 1);
    for (k = 0; k < MAX_COUNT + 3; k++)
      send_item(VALUE_BITS'($urandom_range(0, 7)), VALUE_BITS'($urandom),
                k == MAX_COUNT + 2);
    wait_for_results();
  endtask

  // long receiver hold-off while two sets are offered back to back
  task automatic test_backpressure();
    int s;
    int k;
    hold_reqs++;
    for (s = 0; s < 2; s++)
      for (k = 0; k < 12; k++)
        send_item(VALUE_BITS'($urandom), VALUE_BITS'($urandom), k == 11);
    wait_for_results();
  endtask

  task automatic test_random_sets();
    int                    stored;
    int                    next_cfg;
    int                    n;
    int                    k;
    int                    mode;
    logic [VALUE_BITS-1:0] x;
    logic [VALUE_BITS-1:0] y;
    stored   = 0;
    next_cfg = 0;
    while (stored < ITEM_GOAL) begin
      if (stored >= next_cfg) begin
        wait_for_results();
        set_shift($urandom_range(0, 1), pick_shift(), pick_shift());
        next_cfg = stored + $urandom_range(50, 110);
      end
      // small pools with negated pairs give plenty of key ties
      for (k = 0; k < 2; k++) begin
        x = $urandom_range(0, 1) ? VALUE_BITS'($urandom) : VALUE_BITS'($urandom_range(0, 15) - 8);
        y = $urandom_range(0, 1) ? VALUE_BITS'($urandom) : VALUE_BITS'($urandom_range(0, 15) - 8);
        pool_r[2*k]   = x;
        pool_r[2*k+1] = -x;
        pool_i[2*k]   = y;
        pool_i[2*k+1] = -y;
      end
      n    = pick_size();
      mode = $urandom_range(0, 2);
      for (k = 0; k < n; k++)
        send_item(pick_value(mode, 1'b0), pick_value(mode, 1'b1), k == n - 1);
      stored += (n < MAX_COUNT) ? n : MAX_COUNT;
    end
    wait_for_results();
  endtask

  // result side stall pattern, with an occasional long hold-off on request
  always @(negedge clk) begin
    if (hold_left == 0 && hold_reqs != holds_started) begin
      holds_started++;
      hold_left = HOLD_CYCLES;
    end
    if (hold_left > 0) begin
      hold_left--;
      result_stall <= 1'b1;
    end else begin
      if (mode_left == 0) begin
        stall_mode = $urandom_range(0, 3);
        mode_left  = $urandom_range(8, 150);
      end else begin
        mode_left--;
      end
      stall_phase++;
      case (stall_mode)
        0:       result_stall <= 1'b0;
        1:       result_stall <= ($urandom_range(0, 3) == 0);
        2:       result_stall <= ($urandom_range(0, 3) != 0);
        default: result_stall <= (stall_phase % 3 == 0);
      endcase
    end
  end

  out_item_t want;

  always @(posedge clk) begin
    if (!rst && result_valid && !result_stall) begin
      if (sorted_q.size() == 0) begin
        report_error($sformatf("unexpected item real=%0d index=%0d",
                               result.sorted_real, result.original_index));
      end else begin
        want = sorted_q.pop_front();
        if (result.sorted_real !== want.sorted_real)
          report_error($sformatf("sorted_real got %0d want %0d",
                                 result.sorted_real, want.sorted_real));
        if (result.sorted_imag !== want.sorted_imag)
          report_error($sformatf("sorted_imag got %0d want %0d",
                                 result.sorted_imag, want.sorted_imag));
        if (result.original_index !== want.original_index)
          report_error($sformatf("original_index got %0d want %0d",
                                 result.original_index, want.original_index));
        if (result.dropped_flag !== want.dropped_flag)
          report_error($sformatf("dropped_flag got %0b want %0b",
                                 result.dropped_flag, want.dropped_flag));
        if (result.last_out !== want.last_out)
          report_error($sformatf("last_out got %0b want %0b",
                                 result.last_out, want.last_out));
      end
    end
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("ERROR: timeout, %0d items still expected", sorted_q.size());
      $display("Simulation FAILED");
      $finish;
    end
  end

  initial begin
    rst         = 1'b1;
    item_valid  = 1'b0;
    item        = '0;
    cfg_we      = 1'b0;
    cfg_index   = CFG_SHIFT_ENABLE;
    cfg_data    = '0;
    set_dropped = 1'b0;
    sh_en       = 1'b0;
    sh_re       = 0;
    sh_im       = 0;
    repeat (4) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    test_extremes();
    test_ties();
    test_shift_order();
    test_capacity();
    test_backpressure();
    test_random_sets();

    wait_for_results();
    if (mismatch_count == 0 && sorted_q.size() == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule
